// ===== hdl/dpb_pkg.sv =====
package dpb_pkg;

  localparam int SIZE_BITS      = 13;
  localparam int PARAM_BITS     = 16;
  localparam int COORD_BITS     = 13;
  localparam int DEPTH_BITS     = 15;
  localparam int MAG_BITS       = COORD_BITS + 4;
  localparam int PROD_BITS      = MAG_BITS + DEPTH_BITS;
  localparam int DIVIDEND_BITS  = PROD_BITS + 6;
  localparam int DIVISOR_BITS   = PARAM_BITS + 1;
  localparam int POS_BITS       = 24;
  localparam int REG_INDEX_BITS = 3;
  localparam int REG_DATA_BITS  = 16;

  localparam logic [SIZE_BITS-1:0]  RESET_IMAGE_WIDTH  = 13'd640;
  localparam logic [SIZE_BITS-1:0]  RESET_IMAGE_HEIGHT = 13'd480;
  localparam logic [PARAM_BITS-1:0] RESET_FOCAL_X      = 16'd8400;
  localparam logic [PARAM_BITS-1:0] RESET_FOCAL_Y      = 16'd8400;
  localparam logic [PARAM_BITS-1:0] RESET_CENTER_X     = 16'd5112;
  localparam logic [PARAM_BITS-1:0] RESET_CENTER_Y     = 16'd3832;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_FOCAL_X      = 3'd2,
    REG_FOCAL_Y      = 3'd3,
    REG_CENTER_X     = 3'd4,
    REG_CENTER_Y     = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]  image_width;
    logic [SIZE_BITS-1:0]  image_height;
    logic [PARAM_BITS-1:0] focal_x;
    logic [PARAM_BITS-1:0] focal_y;
    logic [PARAM_BITS-1:0] center_x;
    logic [PARAM_BITS-1:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [DEPTH_BITS-1:0] depth;
    logic                  point;
    logic                  last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hdl/dpb_front.sv =====
module dpb_front #(
  parameter int SAMPLE_STRIDE = 4,
  parameter int DIM_BITS      = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  dpb_pkg::cfg_t       cfg,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  logic signed [15:0]  depth_mm,
  input  dpb_pkg::queue_status_t q_status,
  output logic                push,
  output dpb_pkg::job_t       job
);

  localparam int PHASE_BITS = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
  localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(SAMPLE_STRIDE - 1);
  localparam logic [dpb_pkg::SIZE_BITS:0] DIM_TOP =
    (dpb_pkg::SIZE_BITS + 1)'(1) << DIM_BITS;

  logic [DIM_BITS-1:0]   column_count;
  logic [DIM_BITS-1:0]   row_count;
  logic [PHASE_BITS-1:0] col_phase;
  logic [PHASE_BITS-1:0] row_phase;
  logic [DIM_BITS-1:0]   col_last;
  logic [DIM_BITS-1:0]   row_last;
  logic                  row_end;
  logic                  last;
  logic                  kept;
  logic                  positive;
  logic                  accept;

  function automatic logic [DIM_BITS-1:0] last_index(input logic [dpb_pkg::SIZE_BITS-1:0] v);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if ({1'b0, v} > DIM_TOP) begin
      r = '1;
    end else begin
      r = DIM_BITS'(v - 1'b1);
    end
    return r;
  endfunction

  function automatic logic [PHASE_BITS-1:0] next_phase(input logic [PHASE_BITS-1:0] p);
    return (p == PHASE_LAST) ? '0 : PHASE_BITS'(p + 1'b1);
  endfunction

  assign col_last    = last_index(cfg.image_width);
  assign row_last    = last_index(cfg.image_height);
  assign row_end     = column_count >= col_last;
  assign last        = row_end && (row_count >= row_last);
  assign kept        = (col_phase == '0) && (row_phase == '0);
  assign positive    = !depth_mm[15] && (depth_mm != '0);
  assign pixel_stall = q_status.full;
  assign accept      = pixel_valid && !q_status.full;
  assign push        = accept && ((kept && positive) || last);

  always_comb begin
    job.column = dpb_pkg::COORD_BITS'(column_count);
    job.row    = dpb_pkg::COORD_BITS'(row_count);
    job.depth  = depth_mm[dpb_pkg::DEPTH_BITS-1:0];
    job.point  = kept && positive;
    job.last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      col_phase    <= '0;
      row_phase    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        col_phase    <= '0;
        if (last) begin
          row_count <= '0;
          row_phase <= '0;
        end else begin
          row_count <= DIM_BITS'(row_count + 1'b1);
          row_phase <= next_phase(row_phase);
        end
      end else begin
        column_count <= DIM_BITS'(column_count + 1'b1);
        col_phase    <= next_phase(col_phase);
      end
    end
  end

endmodule

// ===== hdl/dpb_queue.sv =====
module dpb_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  dpb_pkg::job_t          push_job,
  input  logic                   pop,
  output dpb_pkg::job_t          head,
  output dpb_pkg::queue_status_t status
);

  localparam int CW = $clog2(DEPTH + 1);

  dpb_pkg::job_t  entries [DEPTH];
  logic [CW-1:0]  count;

  // head always sits in entry 0; a pop shifts the queue down
  assign head         = entries[0];
  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case ({push, pop})
        2'b10:   count <= CW'(count + 1'b1);
        2'b01:   count <= CW'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop) begin
        if (push && (CW'(i + 1) == count)) begin
          entries[i] <= push_job;
        end else if (i < DEPTH - 1) begin
          entries[i] <= entries[(i < DEPTH - 1) ? i + 1 : i];
        end
      end else if (push && (CW'(i) == count)) begin
        entries[i] <= push_job;
      end
    end
  end

endmodule

// ===== hdl/dpb_div.sv =====
module dpb_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [dpb_pkg::DIVIDEND_BITS-1:0]   dividend,
  input  logic [dpb_pkg::DIVISOR_BITS-1:0]    divisor,
  output logic                                done,
  output logic [dpb_pkg::DIVIDEND_BITS-1:0]   quotient
);

  localparam int NB = dpb_pkg::DIVIDEND_BITS;
  localparam int DB = dpb_pkg::DIVISOR_BITS;
  localparam int CNT_BITS = $clog2(NB + 1);

  logic [DB-1:0]       rem;
  logic [NB-1:0]       quo;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [DB:0]         shifted;
  logic [DB:0]         trial;
  logic                fits;

  // restoring division, one quotient bit per cycle
  assign shifted  = {rem, quo[NB-1]};
  assign trial    = shifted - {1'b0, divisor};
  assign fits     = !trial[DB];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(NB);
      end else if (busy) begin
        cnt <= CNT_BITS'(cnt - 1'b1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? trial[DB-1:0] : shifted[DB-1:0];
      quo <= {quo[NB-2:0], fits};
    end
  end

endmodule

// ===== hdl/dpb_back.sv =====
module dpb_back (
  input  logic                            clk,
  input  logic                            rst,
  input  dpb_pkg::cfg_t                   cfg,
  input  dpb_pkg::queue_status_t          q_status,
  input  dpb_pkg::job_t                   head,
  output logic                            pop,
  output logic                            point_valid,
  input  logic                            point_stall,
  output logic signed [23:0]              pos_x,
  output logic signed [23:0]              pos_y,
  output logic [14:0]                     pos_z,
  output logic                            has_point,
  output logic                            frame_end
);

  localparam int MB = dpb_pkg::MAG_BITS;
  localparam int PB = dpb_pkg::PROD_BITS;
  localparam int NB = dpb_pkg::DIVIDEND_BITS;
  localparam int DB = dpb_pkg::DIVISOR_BITS;
  localparam int QB = dpb_pkg::POS_BITS;
  localparam logic [NB-1:0] POS_MAX_Q     = NB'((1 << (QB - 1)) - 1);
  localparam logic [NB-1:0] POS_MIN_MAG_Q = NB'(1 << (QB - 1));
  localparam logic [QB-1:0] POS_MAX_CODE  = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] POS_MIN_CODE  = {1'b1, {(QB-1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                        state;
  dpb_pkg::job_t                 job;
  logic [PB-1:0]                 prod_x;
  logic [PB-1:0]                 prod_y;
  logic                          neg_x;
  logic                          neg_y;
  logic signed [MB:0]            diff_x;
  logic signed [MB:0]            diff_y;
  logic [MB-1:0]                 mag_x;
  logic [MB-1:0]                 mag_y;
  logic [dpb_pkg::PARAM_BITS-1:0] fx;
  logic [dpb_pkg::PARAM_BITS-1:0] fy;
  logic [NB-1:0]                 dividend_x;
  logic [NB-1:0]                 dividend_y;
  logic [DB-1:0]                 divisor_x;
  logic [DB-1:0]                 divisor_y;
  logic [NB-1:0]                 quo_x;
  logic [NB-1:0]                 quo_y;
  logic                          done_x;
  logic                          done_y;
  logic                          div_start;
  logic                          out_free;

  function automatic logic [QB-1:0] saturate(input logic [NB-1:0] q, input logic neg);
    logic [QB-1:0] r;
    if (neg) begin
      r = (q > POS_MIN_MAG_Q) ? POS_MIN_CODE : QB'(-q[QB-1:0]);
    end else begin
      r = (q > POS_MAX_Q) ? POS_MAX_CODE : q[QB-1:0];
    end
    return r;
  endfunction

  assign diff_x = $signed({1'b0, job.column, 4'b0000}) - $signed((MB + 1)'(cfg.center_x));
  assign diff_y = $signed({1'b0, job.row, 4'b0000}) - $signed((MB + 1)'(cfg.center_y));
  assign mag_x  = diff_x[MB] ? MB'(-diff_x) : MB'(diff_x);
  assign mag_y  = diff_y[MB] ? MB'(-diff_y) : MB'(diff_y);

  // zero focal length counts as one
  assign fx = (cfg.focal_x == '0) ? dpb_pkg::PARAM_BITS'(1) : cfg.focal_x;
  assign fy = (cfg.focal_y == '0) ? dpb_pkg::PARAM_BITS'(1) : cfg.focal_y;

  // round to nearest: (2*num + f) / (2*f), num = mag * depth * 16
  assign dividend_x = NB'({prod_x, 5'b00000}) + NB'(fx);
  assign dividend_y = NB'({prod_y, 5'b00000}) + NB'(fy);
  assign divisor_x  = {fx, 1'b0};
  assign divisor_y  = {fy, 1'b0};

  assign div_start = state == S_LOAD;
  assign pop       = (state == S_IDLE) && !q_status.empty;
  assign out_free  = !point_valid || !point_stall;

  dpb_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend_x),
    .divisor  (divisor_x),
    .done     (done_x),
    .quotient (quo_x)
  );

  dpb_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend_y),
    .divisor  (divisor_y),
    .done     (done_y),
    .quotient (quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        point_valid <= 1'b1;
      end else if (!point_stall) begin
        point_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            state <= head.point ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (done_x && done_y) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (state == S_MUL) begin
      prod_x <= PB'(mag_x) * PB'(job.depth);
      prod_y <= PB'(mag_y) * PB'(job.depth);
      neg_x  <= diff_x[MB];
      neg_y  <= diff_y[MB];
    end
    if ((state == S_DONE) && out_free) begin
      frame_end <= job.last;
      has_point <= job.point;
      if (job.point) begin
        pos_x <= saturate(quo_x, neg_x);
        pos_y <= saturate(quo_y, neg_y);
        pos_z <= job.depth;
      end else begin
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
      end
    end
  end

endmodule

// ===== hdl/depth_pixel_backprojection.sv =====
// Path: an accepted pixel's job waits in the job queue; the idle back end pops it and
// goes to its done state for a frame end word without a point, or through multiply,
// load and the 38-step bit-serial dividers for a point. Throughput: one pixel per cycle
// while the job queue has room; the back end works on one job at a time.
// Reset: counters to the first pixel, queue emptied, registers to their defaults,
// any pending output word dropped.
module depth_pixel_backprojection #(
  parameter int SAMPLE_STRIDE = 4,
  parameter int DIM_BITS      = 12,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  write_enable,
  input  logic [dpb_pkg::REG_INDEX_BITS-1:0]    reg_index,
  input  logic [dpb_pkg::REG_DATA_BITS-1:0]     write_data,
  input  logic                                  pixel_valid,
  output logic                                  pixel_stall,
  input  logic signed [15:0]                    depth_mm,
  output logic                                  point_valid,
  input  logic                                  point_stall,
  output logic signed [23:0]                    pos_x,
  output logic signed [23:0]                    pos_y,
  output logic [14:0]                           pos_z,
  output logic                                  has_point,
  output logic                                  frame_end
);

  dpb_pkg::cfg_t          cfg;
  dpb_pkg::job_t          push_job;
  dpb_pkg::job_t          head;
  dpb_pkg::queue_status_t q_status;
  logic                   q_push;
  logic                   q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= dpb_pkg::RESET_IMAGE_WIDTH;
      cfg.image_height <= dpb_pkg::RESET_IMAGE_HEIGHT;
      cfg.focal_x      <= dpb_pkg::RESET_FOCAL_X;
      cfg.focal_y      <= dpb_pkg::RESET_FOCAL_Y;
      cfg.center_x     <= dpb_pkg::RESET_CENTER_X;
      cfg.center_y     <= dpb_pkg::RESET_CENTER_Y;
    end else if (write_enable) begin
      unique case (dpb_pkg::reg_index_t'(reg_index))
        dpb_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= write_data[dpb_pkg::SIZE_BITS-1:0];
        dpb_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= write_data[dpb_pkg::SIZE_BITS-1:0];
        dpb_pkg::REG_FOCAL_X:      cfg.focal_x      <= write_data;
        dpb_pkg::REG_FOCAL_Y:      cfg.focal_y      <= write_data;
        dpb_pkg::REG_CENTER_X:     cfg.center_x     <= write_data;
        dpb_pkg::REG_CENTER_Y:     cfg.center_y     <= write_data;
        default: begin
        end
      endcase
    end
  end

  dpb_front #(
    .SAMPLE_STRIDE (SAMPLE_STRIDE),
    .DIM_BITS      (DIM_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .depth_mm    (depth_mm),
    .q_status    (q_status),
    .push        (q_push),
    .job         (push_job)
  );

  dpb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head),
    .status   (q_status)
  );

  dpb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_status    (q_status),
    .head        (head),
    .pop         (q_pop),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .has_point   (has_point),
    .frame_end   (frame_end)
  );

`ifndef ASSERT_OFF
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("job pushed into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("job popped from an empty queue");

  a_bare_end: assert property (@(posedge clk) disable iff (rst)
    point_valid && !has_point |->
      frame_end && (pos_x == '0) && (pos_y == '0) && (pos_z == '0))
    else $error("word without point is not a clean frame end");

  a_point_depth: assert property (@(posedge clk) disable iff (rst)
    point_valid && has_point |-> pos_z != '0)
    else $error("point word with zero depth");
`endif

endmodule

// ===== tb/depth_pixel_backprojection_checker.sv =====
`timescale 1ns / 100ps
module depth_pixel_backprojection_checker #(
  parameter int SAMPLE_STRIDE = 4,
  parameter int DIM_BITS      = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [dpb_pkg::REG_INDEX_BITS-1:0] reg_index,
  input  logic [dpb_pkg::REG_DATA_BITS-1:0]  write_data,
  input  logic                               pixel_valid,
  input  logic                               pixel_stall,
  input  logic signed [15:0]                 depth_mm,
  input  logic                               point_valid,
  input  logic                               point_stall,
  input  logic signed [23:0]                 pos_x,
  input  logic signed [23:0]                 pos_y,
  input  logic [14:0]                        pos_z,
  input  logic                               has_point,
  input  logic                               frame_end,
  output int                                 error_count,
  output int                                 pending
);

  localparam longint unsigned POS_MAX     = 64'd8388607;
  localparam longint unsigned POS_MIN_MAG = 64'd8388608;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [14:0]        z;
    logic               has_point;
    logic               frame_end;
  } point_word_t;

  dpb_pkg::cfg_t       cfg;
  logic [DIM_BITS-1:0] column;
  logic [DIM_BITS-1:0] row;
  point_word_t         expected_points[$];
  point_word_t         got;
  point_word_t         want;

  function automatic int unsigned clamp_size(logic [dpb_pkg::SIZE_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > (1 << DIM_BITS)) return 1 << DIM_BITS;
    return 32'(v);
  endfunction

  // (16*pos - centre) * depth * 16 / focal, nearest, ties away from zero, saturated
  function automatic logic [23:0] project_axis(int unsigned pos, logic [15:0] centre,
                                               logic [14:0] depth, logic [15:0] focal);
    longint            diff;
    longint            q;
    longint unsigned   mag;
    longint unsigned   f;
    longint unsigned   num;
    longint unsigned   qu;
    diff = longint'(pos) * 16 - longint'(centre);
    mag  = (diff < 0) ? -diff : diff;
    f    = (focal == 0) ? 64'd1 : 64'(focal);
    num  = mag * 64'(depth) * 64'd16;
    qu   = (2 * num + f) / (2 * f);
    if (diff < 0) begin
      if (qu > POS_MIN_MAG) qu = POS_MIN_MAG;
      q = -longint'(qu);
    end else begin
      if (qu > POS_MAX) qu = POS_MAX;
      q = longint'(qu);
    end
    return q[23:0];
  endfunction

  function automatic void backproject_pixel(logic signed [15:0] depth);
    int unsigned w;
    int unsigned h;
    logic        positive;
    logic        row_done;
    logic        frame_done;
    logic        kept;
    point_word_t word;
    w          = clamp_size(cfg.image_width);
    h          = clamp_size(cfg.image_height);
    positive   = depth > 0;
    row_done   = column >= w - 1;
    frame_done = row_done && (row >= h - 1);
    kept       = (column % SAMPLE_STRIDE == 0) && (row % SAMPLE_STRIDE == 0);
    word       = '0;
    if (kept && positive) begin
      word.x         = project_axis(column, cfg.center_x, depth[14:0], cfg.focal_x);
      word.y         = project_axis(row, cfg.center_y, depth[14:0], cfg.focal_y);
      word.z         = depth[14:0];
      word.has_point = 1'b1;
    end
    word.frame_end = frame_done;
    if ((kept && positive) || frame_done) expected_points = {expected_points, word};
    if (row_done) begin
      column = '0;
      row    = frame_done ? '0 : row + 1'b1;
    end else begin
      column = column + 1'b1;
    end
  endfunction

  always @(posedge clk) begin : watch
    if (rst) begin
      cfg.image_width  = dpb_pkg::RESET_IMAGE_WIDTH;
      cfg.image_height = dpb_pkg::RESET_IMAGE_HEIGHT;
      cfg.focal_x      = dpb_pkg::RESET_FOCAL_X;
      cfg.focal_y      = dpb_pkg::RESET_FOCAL_Y;
      cfg.center_x     = dpb_pkg::RESET_CENTER_X;
      cfg.center_y     = dpb_pkg::RESET_CENTER_Y;
      column           = '0;
      row              = '0;
      error_count      = 0;
      expected_points.delete();
    end else begin
      if (write_enable) begin
        case (reg_index)
          dpb_pkg::REG_IMAGE_WIDTH:  cfg.image_width  = write_data[dpb_pkg::SIZE_BITS-1:0];
          dpb_pkg::REG_IMAGE_HEIGHT: cfg.image_height = write_data[dpb_pkg::SIZE_BITS-1:0];
          dpb_pkg::REG_FOCAL_X:      cfg.focal_x      = write_data;
          dpb_pkg::REG_FOCAL_Y:      cfg.focal_y      = write_data;
          dpb_pkg::REG_CENTER_X:     cfg.center_x     = write_data;
          dpb_pkg::REG_CENTER_Y:     cfg.center_y     = write_data;
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) backproject_pixel(depth_mm);
      if (point_valid && !point_stall) begin
        got = '{pos_x, pos_y, pos_z, has_point, frame_end};
        if (expected_points.size() == 0) begin
          error_count++;
          $display("%0t: unexpected point word x=%0d y=%0d z=%0d point=%0b end=%0b",
                   $time, got.x, got.y, got.z, got.has_point, got.frame_end);
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            error_count++;
            $display("%0t: point word mismatch: expected x=%0d y=%0d z=%0d point=%0b end=%0b",
                     $time, want.x, want.y, want.z, want.has_point, want.frame_end);
            $display("%0t:                      actual   x=%0d y=%0d z=%0d point=%0b end=%0b",
                     $time, got.x, got.y, got.z, got.has_point, got.frame_end);
          end
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

// ===== tb/depth_pixel_backprojection_tb.sv =====
`timescale 1ns / 100ps
module depth_pixel_backprojection_tb;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_PIXELS = 1600;

  // indexes past the register file, ignored by the block
  localparam logic [dpb_pkg::REG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [dpb_pkg::REG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  logic                               clk          = 1'b0;
  logic                               rst          = 1'b1;
  logic                               write_enable = 1'b0;
  logic [dpb_pkg::REG_INDEX_BITS-1:0] reg_index    = '0;
  logic [dpb_pkg::REG_DATA_BITS-1:0]  write_data   = '0;
  logic                               pixel_valid  = 1'b0;
  logic                               pixel_stall;
  logic signed [15:0]                 depth_mm     = '0;
  logic                               point_valid;
  logic                               point_stall  = 1'b0;
  logic signed [23:0]                 pos_x;
  logic signed [23:0]                 pos_y;
  logic [14:0]                        pos_z;
  logic                               has_point;
  logic                               frame_end;

  int errors;
  int pending;
  int send_idle = 20;
  int recv_idle = 46;
  int cycles    = 0;

  depth_pixel_backprojection dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .depth_mm     (depth_mm),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .has_point    (has_point),
    .frame_end    (frame_end)
  );

  depth_pixel_backprojection_checker point_check (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .depth_mm     (depth_mm),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .has_point    (has_point),
    .frame_end    (frame_end),
    .error_count  (errors),
    .pending      (pending)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    point_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("depth_pixel_backprojection_tb failed");
      $finish;
    end
  end

  // all tasks are entered and left at a falling edge
  task automatic write_reg(input logic [dpb_pkg::REG_INDEX_BITS-1:0] idx,
                           input logic [dpb_pkg::REG_DATA_BITS-1:0] data);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= data;
    @(negedge clk);
    write_enable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_pixel(input logic signed [15:0] depth);
    while ($urandom_range(0, 99) < send_idle) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    depth_mm    <= depth;
    do @(posedge clk); while (pixel_stall);
    @(negedge clk);
  endtask

  // quiet the input and let every outstanding word drain
  task automatic settle();
    pixel_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_geometry(input logic [15:0] w, input logic [15:0] h,
                              input logic [15:0] fx, input logic [15:0] fy,
                              input logic [15:0] cx, input logic [15:0] cy);
    settle();
    write_reg(dpb_pkg::REG_IMAGE_WIDTH, w);
    write_reg(dpb_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(dpb_pkg::REG_FOCAL_X, fx);
    write_reg(dpb_pkg::REG_FOCAL_Y, fy);
    write_reg(dpb_pkg::REG_CENTER_X, cx);
    write_reg(dpb_pkg::REG_CENTER_Y, cy);
  endtask

  function automatic logic [15:0] pick_size();
    logic [15:0] v;
    v[15:13] = 3'($urandom);
    case ($urandom_range(0, 9))
      0:       v[12:0] = 13'd0;
      1:       v[12:0] = 13'($urandom_range(4096, 8191));
      2:       v[12:0] = 13'd4096;
      3:       v[12:0] = 13'($urandom_range(25, 300));
      default: v[12:0] = 13'($urandom_range(1, 24));
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_focal();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(16, 4000));
    endcase
  endfunction

  function automatic logic [15:0] pick_centre();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(0, 400));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_depth();
    case ($urandom_range(0, 19))
      0, 1:    return 16'sd0;
      2:       return 16'sh7FFF;
      3:       return 16'sh8000;
      4, 5:    return {1'b1, 15'($urandom)};
      6, 7:    return 16'($urandom);
      default: return 16'($urandom_range(1, 32767));
    endcase
  endfunction

  initial begin : stimulus
    int sent;
    int n;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // short rows, one row per frame; both saturation directions
    settle();
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    set_geometry(16'd5, 16'd1, 16'd1, 16'd1, 16'd0, 16'hFFFF);
    send_pixel(16'sd32767);
    send_pixel(16'sd1);
    send_pixel(-16'sd1);
    send_pixel(16'sd0);
    send_pixel(16'sd32767);
    send_pixel(16'sd0);
    send_pixel(16'sd100);
    send_pixel(16'sd200);
    send_pixel(16'sd300);
    send_pixel(-16'sd32768);

    // zero sizes and zero focal lengths: every pixel ends a frame
    set_geometry(16'hE000, 16'h0000, 16'd0, 16'd0, 16'd8, 16'd0);
    send_pixel(16'sd1);
    send_pixel(16'sd0);
    send_pixel(-16'sd32768);
    send_pixel(16'sd32767);

    // largest image, then shrink it under the running counters
    set_geometry(16'hF000, 16'h1FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'sd32767);
    send_pixel(16'sd5000);
    send_pixel(16'sd32767);
    send_pixel(16'sd1);
    send_pixel(16'sd32767);
    settle();
    write_reg(dpb_pkg::REG_IMAGE_WIDTH, 16'h0003);
    send_pixel(16'sd7);
    send_pixel(16'sd8);
    send_pixel(16'sd9);
    settle();
    write_reg(dpb_pkg::REG_IMAGE_HEIGHT, 16'h0001);
    send_pixel(16'sd10);
    send_pixel(16'sd20);
    send_pixel(16'sd30);

    for (int m = 0; m < 3; m++) begin
      case (m)
        0:       begin send_idle = 20; recv_idle = 46; end
        1:       begin send_idle = 46; recv_idle = 20; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      sent = 0;
      while (sent < RANDOM_PIXELS / 3) begin
        set_geometry(pick_size(), pick_size(), pick_focal(), pick_focal(),
                     pick_centre(), pick_centre());
        if ($urandom_range(0, 3) == 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
        n = $urandom_range(40, 160);
        if (n > RANDOM_PIXELS / 3 - sent) n = RANDOM_PIXELS / 3 - sent;
        repeat (n) begin
          send_pixel(pick_depth());
          sent++;
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("depth_pixel_backprojection_tb passed");
    end else begin
      $display("depth_pixel_backprojection_tb failed");
    end
    $finish;
  end

endmodule

// ===== depth_pixel_backprojection.f =====
hdl/dpb_pkg.sv
hdl/dpb_front.sv
hdl/dpb_queue.sv
hdl/dpb_div.sv
hdl/dpb_back.sv
hdl/depth_pixel_backprojection.sv
tb/depth_pixel_backprojection_checker.sv
tb/depth_pixel_backprojection_tb.sv
